[hw/rtl/rhs_pkg.sv]
// shared types and constants of the ransac hypothesis scorer
`timescale 1ns / 1ps

package rhs_pkg;

    localparam int RES_W     = 32;
    localparam int HYP_W     = 16;
    localparam int CNT_W     = 13;
    localparam int SUM_W     = 44;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 120;

    localparam int MAX_POINTS = 4096;
    localparam int CNT_LIMIT_I = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;

    localparam logic [CNT_W-1:0] CNT_LIMIT     = CNT_W'(CNT_LIMIT_I);
    localparam logic [SUM_W-1:0] SUM_ALL_ONES  = {SUM_W{1'b1}};
    localparam logic [RES_W-1:0] THRESH_RESET  = RES_W'(65536);
    localparam logic [CNT_W-1:0] MIN_INL_RESET = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INLIERS = 1'b1;

    typedef struct packed {
        logic [RES_W-1:0] residual;
        logic             inlier;
        logic [HYP_W-1:0] hyp_id;
        logic             given_model;
        logic             last_point;
        logic             last_hypothesis;
    } t_item;

    typedef struct packed {
        logic [CNT_W-1:0] hyp_inliers;
        logic [SUM_W-1:0] hyp_error_sum;
        logic [HYP_W-1:0] chosen_hyp;
        logic             found_valid;
        logic [SUM_W-1:0] winner_error_sum;
        logic             search_done;
    } t_result;

endpackage

[hw/rtl/rhs_score.sv]
// accumulator and best-hypothesis selection state
`timescale 1ns / 1ps

module rhs_score (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  rhs_pkg::t_item            i_item,
    input  logic [rhs_pkg::CNT_W-1:0] i_min_inliers,
    output rhs_pkg::t_result          o_result
);
    import rhs_pkg::*;

    logic [CNT_W-1:0] r_cnt,      n_cnt;
    logic [SUM_W-1:0] r_sum,      n_sum;
    logic [SUM_W-1:0] r_best_sum, n_best_sum;
    logic [HYP_W-1:0] r_best_hyp, n_best_hyp;
    logic             r_valid,    n_valid;
    logic [CNT_W-1:0] r_fb_cnt,   n_fb_cnt;
    logic [HYP_W-1:0] r_fb_hyp,   n_fb_hyp;

    logic [CNT_W-1:0] cnt_acc;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_acc;
    logic             enough;
    logic [SUM_W-1:0] dec_best_sum;
    logic [HYP_W-1:0] dec_best_hyp;
    logic             dec_valid;
    logic [CNT_W-1:0] dec_fb_cnt;
    logic [HYP_W-1:0] dec_fb_hyp;

    always_comb begin
        cnt_acc  = r_cnt;
        sum_wide = {1'b0, r_sum};
        if (i_item.inlier) begin
            if (r_cnt < CNT_LIMIT) begin
                cnt_acc = r_cnt + CNT_W'(1);
            end
            sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(i_item.residual);
        end
        sum_acc = sum_wide[SUM_W] ? SUM_ALL_ONES : sum_wide[SUM_W-1:0];
        enough  = cnt_acc >= i_min_inliers;

        dec_best_sum = r_best_sum;
        dec_best_hyp = r_best_hyp;
        dec_valid    = r_valid;
        dec_fb_cnt   = r_fb_cnt;
        dec_fb_hyp   = r_fb_hyp;
        if (i_item.given_model) begin
            if (enough) begin
                dec_best_sum = sum_acc;
                dec_best_hyp = i_item.hyp_id;
                dec_valid    = 1'b1;
            end else begin
                dec_best_sum = SUM_ALL_ONES;
            end
        end else if (enough && (sum_acc < r_best_sum)) begin
            dec_best_sum = sum_acc;
            dec_best_hyp = i_item.hyp_id;
            dec_valid    = 1'b1;
        end else if ((cnt_acc >= r_fb_cnt) && !r_valid) begin
            dec_fb_cnt = cnt_acc;
            dec_fb_hyp = i_item.hyp_id;
        end

        o_result.hyp_inliers      = cnt_acc;
        o_result.hyp_error_sum    = sum_acc;
        o_result.chosen_hyp       = dec_valid ? dec_best_hyp : dec_fb_hyp;
        o_result.found_valid      = dec_valid;
        o_result.winner_error_sum = dec_best_sum;
        o_result.search_done      = i_item.last_hypothesis;

        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_best_sum = r_best_sum;
        n_best_hyp = r_best_hyp;
        n_valid    = r_valid;
        n_fb_cnt   = r_fb_cnt;
        n_fb_hyp   = r_fb_hyp;
        if (i_step) begin
            if (!i_item.last_point) begin
                n_cnt = cnt_acc;
                n_sum = sum_acc;
            end else if (i_item.last_hypothesis) begin
                n_cnt      = '0;
                n_sum      = '0;
                n_best_sum = SUM_ALL_ONES;
                n_best_hyp = '0;
                n_valid    = 1'b0;
                n_fb_cnt   = '0;
                n_fb_hyp   = '0;
            end else begin
                n_cnt      = '0;
                n_sum      = '0;
                n_best_sum = dec_best_sum;
                n_best_hyp = dec_best_hyp;
                n_valid    = dec_valid;
                n_fb_cnt   = dec_fb_cnt;
                n_fb_hyp   = dec_fb_hyp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_sum      <= '0;
            r_best_sum <= SUM_ALL_ONES;
            r_best_hyp <= '0;
            r_valid    <= 1'b0;
            r_fb_cnt   <= '0;
            r_fb_hyp   <= '0;
        end else begin
            r_cnt      <= n_cnt;
            r_sum      <= n_sum;
            r_best_sum <= n_best_sum;
            r_best_hyp <= n_best_hyp;
            r_valid    <= n_valid;
            r_fb_cnt   <= n_fb_cnt;
            r_fb_hyp   <= n_fb_hyp;
        end
    end

endmodule

[hw/rtl/ransac_hypothesis_scorer.sv]
// top level of the ransac hypothesis scorer
`timescale 1ns / 1ps

// Takes one squared residual per cycle and reports one transaction per finished
// hypothesis (the one whose input carried tlast). Throughput is one residual per
// clock unless output backpressure stalls input. A result passes through the input
// register and the result register: the threshold compare is done ahead of the
// input register, and the inlier accumulate and best-hypothesis compare feed the
// result register. The combinational accumulate and select loop sets the clock
// limit. Output backpressure stalls input only while the result register is full,
// unread and the input register holds an item that closes a hypothesis. Configuration
// is written through a plain write port; the user must write it only while the
// block is idle (unenforced); state is cleared after the final hypothesis.

module ransac_hypothesis_scorer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rhs_pkg::IN_DATA_W-1:0]  i_s_tdata,   // residual, hyp_id
    input  logic [rhs_pkg::IN_USER_W-1:0]  i_s_tuser,   // given_model, last_hypothesis
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // hyp_inliers, hyp_error_sum, chosen_hyp, found_valid, winner_error_sum, zero pad
    output logic [rhs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast,
    input  logic                           i_cfg_we,
    input  logic [rhs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rhs_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import rhs_pkg::*;

    localparam int RESULT_W = $bits(t_result) - 1;

    logic [RES_W-1:0] r_thresh;
    logic [CNT_W-1:0] r_min_inl;
    t_item            r_in,  n_in;
    logic             r_in_valid;
    logic [RESULT_W-1:0] r_out;
    logic             r_out_last;
    logic             r_out_valid;
    logic             out_free;
    logic             step;
    t_result          result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= THRESH_RESET;
            r_min_inl <= MIN_INL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD:   r_thresh  <= i_cfg_wdata;
                CFG_MIN_INLIERS: r_min_inl <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && (!r_in.last_point || out_free);
    assign o_s_tready = i_rst_n && (!r_in_valid || step);

    always_comb begin
        n_in.residual        = i_s_tdata[RES_W-1:0];
        n_in.inlier          = i_s_tdata[RES_W-1:0] <= r_thresh;
        n_in.hyp_id          = i_s_tdata[RES_W+HYP_W-1:RES_W];
        n_in.given_model     = i_s_tuser[0];
        n_in.last_point      = i_s_tlast;
        n_in.last_hypothesis = i_s_tuser[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in <= n_in;
        end
    end

    rhs_score u_score (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in),
        .i_min_inliers (r_min_inl),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.last_point) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_point) begin
            r_out <= {result.winner_error_sum, result.found_valid, result.chosen_hyp,
                      result.hyp_error_sum, result.hyp_inliers};
            r_out_last <= result.search_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - RESULT_W)'(0), r_out};
    assign o_m_tlast  = r_out_last;

endmodule

[hw/rtl/rhs_checker.sv]
// port-level checks of the ransac hypothesis scorer and their bind
`timescale 1ns / 1ps

module rhs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [rhs_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);
    import rhs_pkg::*;

    localparam int FOUND_BIT = CNT_W + SUM_W + HYP_W;
    localparam int BEST_LSB  = FOUND_BIT + 1;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // best sum reads all ones until a valid hypothesis exists
    a_none_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[FOUND_BIT] |->
            o_m_tdata[BEST_LSB+SUM_W-1:BEST_LSB] == SUM_ALL_ONES)
        else $error("best sum set without a valid hypothesis");

    // inlier count never passes its saturation limit
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[CNT_W-1:0] <= CNT_LIMIT)
        else $error("inlier count above limit");

endmodule

bind ransac_hypothesis_scorer rhs_checker u_rhs_checker (.*);
